/* sv/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, constants and helpers of the linear blend skinning unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lbs_pkg;

  // Size of the bone matrix table.
  localparam int unsigned NUM_BONES      = 64;
  localparam int unsigned ELEMS_PER_BONE = 12;
  localparam int unsigned MEM_DEPTH      = NUM_BONES * ELEMS_PER_BONE;
  localparam int unsigned ADDR_W         = $clog2(MEM_DEPTH);
  localparam int unsigned ELEM_W         = 4;

  localparam logic [15:0]       NONE_BONE = 16'hFFFF;
  localparam logic [ELEM_W-1:0] LAST_ELEM = ELEM_W'(ELEMS_PER_BONE - 1);

  // Column index of each element within a row; the translation element is the last column.
  localparam logic [1:0] COL_X     = 2'd0;
  localparam logic [1:0] COL_Y     = 2'd1;
  localparam logic [1:0] COL_Z     = 2'd2;
  localparam logic [1:0] COL_TRANS = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } lbs_state_e;

  typedef struct packed {
    logic              accept;    // an input beat is taken this cycle
    logic              issue;     // read one matrix element this cycle
    logic [ELEM_W-1:0] elem;      // element being read, row * 4 + column
    logic              out_load;  // move the accumulators to the output and clear them
  } lbs_cmd_t;

  typedef struct packed {
    logic in_infl;    // the beat on the input is an influence
    logic in_use;     // the influence contributes to the vertex
    logic in_last;    // the influence closes the vertex
    logic pipe_busy;  // an element is still on its way to the accumulators
  } lbs_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/lbs_ctrl.sv */
// ----------------------------------------------------------------------------
// lbs_ctrl
// Sequencer: takes input beats, walks the twelve matrix elements of an
// influence and hands a finished vertex to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire lbs_pkg::lbs_status_t status_i,
  output lbs_pkg::lbs_cmd_t        cmd_o
);
  import lbs_pkg::*;

  lbs_state_e        state_q, state_d;
  logic [ELEM_W-1:0] elem_q, elem_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    elem_d  = '0;
    last_d  = last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.in_infl) begin
          last_d = status_i.in_last;
          if (status_i.in_use) begin
            state_d = ST_ISSUE;
          end else if (status_i.in_last) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_ISSUE: begin
        elem_d = elem_q + ELEM_W'(1);
        if (elem_q == LAST_ELEM) begin
          state_d = ST_DRAIN;
          elem_d  = '0;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = last_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    cmd_o.accept   = accept;
    cmd_o.elem     = elem_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        cmd_o.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elem_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elem_q      <= elem_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* sv/lbs_datapath.sv */
// ----------------------------------------------------------------------------
// lbs_datapath
// Matrix table, element pipeline (read, multiply, row sum, weight multiply,
// accumulate), accumulators and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbs_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lbs_pkg::lbs_cmd_t   cmd_i,
  output lbs_pkg::lbs_status_t     status_o,
  input  wire logic                action_i,
  input  wire logic [5:0]          load_bone_i,
  input  wire logic [3:0]          load_element_i,
  input  wire logic signed [31:0]  load_value_i,
  input  wire logic signed [31:0]  pos_x_i,
  input  wire logic signed [31:0]  pos_y_i,
  input  wire logic signed [31:0]  pos_z_i,
  input  wire logic [15:0]         bone_id_i,
  input  wire logic signed [15:0]  weight_i,
  input  wire logic                last_influence_i,
  output logic signed [31:0]       out_x_o,
  output logic signed [31:0]       out_y_o,
  output logic signed [31:0]       out_z_o
);
  import lbs_pkg::*;

  logic signed [31:0] mem [MEM_DEPTH];

  // Latched influence.
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [15:0] weight_q;
  logic [ADDR_W-1:0]  base_q;

  logic               load_ok, mem_we;
  logic [ADDR_W-1:0]  wr_addr, rd_addr, bone_addr;

  // Pipeline.
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [1:0]         col1_q, row1_q;
  logic signed [31:0] rdata_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] m2_q;
  logic               const2_q, first2_q;
  logic [1:0]         row2_q, row3_q, row4_q;
  logic signed [49:0] row_sum_q, row_sum_d, term;
  logic signed [31:0] psel;
  logic signed [47:0] wprod_q;
  logic signed [63:0] contrib;
  logic signed [63:0] acc_q [3];
  logic signed [31:0] out_x_q, out_y_q, out_z_q;

  assign load_ok = (32'(load_bone_i) < 32'(NUM_BONES))
                && (32'(load_element_i) < 32'(ELEMS_PER_BONE));
  assign mem_we  = cmd_i.accept && !action_i && load_ok;
  assign wr_addr = (ADDR_W'(load_bone_i) << 3) + (ADDR_W'(load_bone_i) << 2)
                 + ADDR_W'(load_element_i);
  assign bone_addr = (ADDR_W'(bone_id_i) << 3) + (ADDR_W'(bone_id_i) << 2);
  assign rd_addr   = base_q + ADDR_W'(cmd_i.elem);

  assign status_o.in_infl   = action_i;
  assign status_o.in_use    = (bone_id_i != NONE_BONE)
                           && (32'(bone_id_i) < 32'(NUM_BONES))
                           && (weight_i > 16'sd0);
  assign status_o.in_last   = last_influence_i;
  assign status_o.pipe_busy = v1_q || v2_q || v3_q || v4_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= load_value_i;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && action_i) begin
      px_q     <= pos_x_i;
      py_q     <= pos_y_i;
      pz_q     <= pos_z_i;
      weight_q <= weight_i;
      base_q   <= bone_addr;
    end
  end

  always_comb begin
    case (col1_q)
      COL_X:   psel = px_q;
      COL_Y:   psel = py_q;
      COL_Z:   psel = pz_q;
      default: psel = '0;
    endcase
  end

  // Arithmetic right shifts give the floor of the scaled products.
  always_comb begin
    term      = const2_q ? 50'(m2_q) : 50'(prod_q >>> 16);
    row_sum_d = (first2_q ? 50'sd0 : row_sum_q) + term;
    contrib   = 64'(wprod_q >>> 14);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q && const2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col1_q   <= cmd_i.elem[1:0];
    row1_q   <= cmd_i.elem[3:2];
    prod_q   <= rdata_q * psel;
    m2_q     <= rdata_q;
    const2_q <= (col1_q == COL_TRANS);
    first2_q <= (col1_q == COL_X);
    row2_q   <= row1_q;
    if (v2_q) begin
      row_sum_q <= row_sum_d;
    end
    row3_q   <= row2_q;
    wprod_q  <= sat32(64'(row_sum_q)) * weight_q;
    row4_q   <= row3_q;
  end

  // Accumulators with saturation to 64 bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [64:0] sum;
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= '0;
      end
    end else if (cmd_i.out_load) begin
      for (int r = 0; r < 3; r++) begin
        acc_q[r] <= '0;
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        sum = {acc_q[r][63], acc_q[r]} + {contrib[63], contrib};
        if (v4_q && (row4_q == 2'(r))) begin
          if (sum[64] != sum[63]) begin
            acc_q[r] <= sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            acc_q[r] <= sum[63:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q <= sat32(acc_q[0]);
      out_y_q <= sat32(acc_q[1]);
      out_z_q <= sat32(acc_q[2]);
    end
  end

  assign out_x_o = out_x_q;
  assign out_y_o = out_y_q;
  assign out_z_o = out_z_q;

endmodule

`default_nettype wire

/* sv/linear_blend_skinning_unit.sv */
// ----------------------------------------------------------------------------
// linear_blend_skinning_unit
// Blends vertices by weighted bone matrices held in an on-chip table.
// ----------------------------------------------------------------------------
// A load beat (action 0) writes one Q16.16 matrix element. An influence
// beat (action 1) reads the twelve elements of its bone one per cycle
// through the single read port of the matrix memory, so it occupies the
// block through its accept, the twelve reads and the drain of the multiply
// and accumulate pipeline, plus the load of the output register when it is
// the last influence of a vertex. A skipped influence takes only its accept,
// plus the output load if it is the last. The result register lets the next
// input beat be taken while a finished vertex waits on the output.
`default_nettype none

module linear_blend_skinning_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic [5:0]         load_bone_i,
  input  wire logic [3:0]         load_element_i,
  input  wire logic signed [31:0] load_value_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic [15:0]        bone_id_i,
  input  wire logic signed [15:0] weight_i,
  input  wire logic               last_influence_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o
);
  import lbs_pkg::*;

  lbs_cmd_t    cmd;
  lbs_status_t status;

  lbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lbs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .action_i         (action_i),
    .load_bone_i      (load_bone_i),
    .load_element_i   (load_element_i),
    .load_value_i     (load_value_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .bone_id_i        (bone_id_i),
    .weight_i         (weight_i),
    .last_influence_i (last_influence_i),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_z_o          (out_z_o)
  );

endmodule

`default_nettype wire
